// File: rtl/core/cpu16ex_pkg.sv
// Package for the cpu16 register/ALU execute block.
// Holds the opcode group, shift and jump codes, the register file type and byte helpers.
// No dependencies.
package cpu16ex_pkg;

  localparam int IN_W  = 48;
  localparam int OUT_W = 104;

  typedef logic [3:0][15:0] rfile_t;

  typedef enum logic [3:0] {
    GRP_MOV   = 4'h0,
    GRP_MOVI  = 4'h1,
    GRP_SPMOV = 4'h2,
    GRP_BMOV  = 4'h3,
    GRP_MEMB  = 4'h4,
    GRP_PUSH  = 4'h5,
    GRP_POP   = 4'h6,
    GRP_LOGIC = 4'h7,
    GRP_INCW  = 4'h8,
    GRP_INCB  = 4'h9,
    GRP_ADD   = 4'hA,
    GRP_ADDI  = 4'hB,
    GRP_SUB   = 4'hC,
    GRP_SUBI  = 4'hD,
    GRP_SHIFT = 4'hE,
    GRP_JUMP  = 4'hF
  } opgrp_t;

  localparam logic [2:0] SH_SHL  = 3'd0;
  localparam logic [2:0] SH_SHR  = 3'd1;
  localparam logic [2:0] SH_SHL2 = 3'd2;
  localparam logic [2:0] SH_SAR  = 3'd3;
  localparam logic [2:0] SH_ROL  = 3'd4;
  localparam logic [2:0] SH_ROR  = 3'd5;

  localparam logic [3:0] JC_JMP = 4'd0;
  localparam logic [3:0] JC_JZ  = 4'd1;
  localparam logic [3:0] JC_JS  = 4'd2;
  localparam logic [3:0] JC_JO  = 4'd3;
  localparam logic [3:0] JC_JNZ = 4'd5;
  localparam logic [3:0] JC_JNS = 4'd6;
  localparam logic [3:0] JC_JNO = 4'd7;

  localparam logic [1:0] LG_AND = 2'd0;
  localparam logic [1:0] LG_OR  = 2'd1;
  localparam logic [1:0] LG_XOR = 2'd2;
  localparam logic [1:0] LG_NOT = 2'd3;

  localparam logic [15:0] SP_RESET = 16'h00FF;

  function automatic logic [7:0] rd8(rfile_t rf, logic [2:0] i);
    return i[2] ? rf[i[1:0]][15:8] : rf[i[1:0]][7:0];
  endfunction

  function automatic rfile_t wr8(rfile_t rf, logic [2:0] i, logic [7:0] v);
    rfile_t r;
    r = rf;
    if (i[2]) begin
      r[i[1:0]][15:8] = v;
    end else begin
      r[i[1:0]][7:0] = v;
    end
    return r;
  endfunction

  function automatic logic [15:0] logic16(logic [1:0] sel, logic [15:0] a, logic [15:0] b);
    logic [15:0] r;
    case (sel)
      LG_AND:  r = a & b;
      LG_OR:   r = a | b;
      LG_XOR:  r = a ^ b;
      default: r = ~a;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] logic8(logic [1:0] sel, logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    case (sel)
      LG_AND:  r = a & b;
      LG_OR:   r = a | b;
      LG_XOR:  r = a ^ b;
      default: r = ~a;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/custom_cpu16_register_alu_execute_top.sv
// Execute stage of a custom 16-bit machine: register file, stack pointer, flags and ALU.
// Depends on cpu16ex_pkg.
//
// Usage:
//   in_*  : one already-fetched instruction per beat (opcode, operand byte, immediate,
//           fall-through address).
//   out_* : one result beat per instruction with all four registers, the stack pointer,
//           the flags, the next address, the branch-taken and not-handled marks.
//   The result beat is registered; throughput is one instruction per cycle while the
//   receiver does not stall. The decode, ALU and shifter run in one combinational pass
//   from the accepted beat and the architectural registers into the state and result
//   registers, so each instruction sees the state left by the one before it.
//   The result register parts the channels: a new beat is taken whenever the result
//   register is empty or being drained in the same cycle. When the receiver stalls
//   with a result held, in_tready drops and the state holds.
//   Reset clears the registers and flags, sets the stack pointer to 0x00FF and
//   empties the result register; a beat can be taken in the first cycle after reset.
module custom_cpu16_register_alu_execute_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // action[7:0], operand_byte[15:8], immediate[31:16], fall_through_pc[47:32]
  input  logic [cpu16ex_pkg::IN_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // reg_a[15:0], reg_b[31:16], reg_c[47:32], reg_d[63:48], stack_pointer[79:64],
  // zero_flag[80], sign_flag[81], overflow_flag[82], next_pc[98:83],
  // branch_taken[99], not_handled[100], zero fill[103:101]
  output logic [cpu16ex_pkg::OUT_W-1:0] out_tdata
);
  import cpu16ex_pkg::*;

  rfile_t              rf_r, rf_nxt;
  logic [15:0]         sp_r, sp_nxt;
  logic                zf_r, zf_nxt, sf_r, sf_nxt, of_r, of_nxt;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r, out_data_nxt;

  logic                accept;
  opgrp_t              grp;
  logic [3:0]          lo;
  logic [7:0]          aux;
  logic [15:0]         imm, pc;
  logic [1:0]          d16, s16;

  logic [15:0]         npc;
  logic                taken, nh;
  logic [16:0]         sum17;
  logic [8:0]          sum9;
  logic [15:0]         w16;
  logic [7:0]          b8;

  logic [3:0]          sh_amt;
  logic [15:0]         shw_v, shw;
  logic [31:0]         shw_rl, shw_rr;
  logic [7:0]          shb_v, shb;
  logic [15:0]         shb_rl, shb_rr;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign grp = opgrp_t'(in_tdata[7:4]);
  assign lo  = in_tdata[3:0];
  assign aux = in_tdata[15:8];
  assign imm = in_tdata[31:16];
  assign pc  = in_tdata[47:32];
  assign d16 = in_tdata[1:0];
  assign s16 = in_tdata[3:2];

  // shifter
  always_comb begin
    sh_amt = aux[7:4];
    shw_v  = rf_r[aux[1:0]];
    shw_rl = {shw_v, shw_v} << sh_amt;
    shw_rr = {shw_v, shw_v} >> sh_amt;
    shb_v  = rd8(rf_r, aux[2:0]);
    shb_rl = {shb_v, shb_v} << sh_amt[2:0];
    shb_rr = {shb_v, shb_v} >> sh_amt[2:0];
    case (lo[2:0])
      SH_SHL, SH_SHL2: begin
        shw = shw_v << sh_amt;
        shb = shb_v << sh_amt;
      end
      SH_SHR: begin
        shw = shw_v >> sh_amt;
        shb = shb_v >> sh_amt;
      end
      SH_SAR: begin
        shw = $signed(shw_v) >>> sh_amt;
        shb = $signed(shb_v) >>> sh_amt[2:0];
      end
      SH_ROL: begin
        shw = shw_rl[31:16];
        shb = shb_rl[15:8];
      end
      SH_ROR: begin
        shw = shw_rr[15:0];
        shb = shb_rr[7:0];
      end
      default: begin
        shw = shw_v;
        shb = shb_v;
      end
    endcase
  end

  always_comb begin
    rf_nxt = rf_r;
    sp_nxt = sp_r;
    zf_nxt = zf_r;
    sf_nxt = sf_r;
    of_nxt = of_r;
    npc    = pc;
    taken  = 1'b0;
    nh     = 1'b0;
    sum17  = '0;
    sum9   = '0;
    w16    = '0;
    b8     = '0;
    unique case (grp)
      GRP_MOV: rf_nxt[d16] = rf_r[s16];
      GRP_MOVI: begin
        if (lo < 4'd4) begin
          rf_nxt[d16] = imm;
        end else if (lo[3]) begin
          nh = 1'b1;
        end
      end
      GRP_SPMOV: begin
        if (lo < 4'd4) begin
          rf_nxt[d16] = sp_r;
        end else if (lo < 4'd8) begin
          sp_nxt = rf_r[d16];
        end
      end
      GRP_BMOV: begin
        if (lo == 4'd0) begin
          rf_nxt = wr8(rf_r, aux[2:0], rd8(rf_r, aux[5:3]));
        end else if (lo[3]) begin
          rf_nxt = wr8(rf_r, lo[2:0], imm[7:0]);
        end
      end
      GRP_MEMB: nh = 1'b1;
      GRP_PUSH, GRP_POP: begin
        if (lo < 4'd5 || lo[3]) begin
          nh = 1'b1;
        end
      end
      GRP_LOGIC: begin
        if (lo[2:0] != 3'd7) begin
          if (lo[3]) begin
            b8 = logic8(lo[1:0], rd8(rf_r, aux[2:0]),
                        lo[2] ? imm[7:0] : rd8(rf_r, aux[5:3]));
            rf_nxt = wr8(rf_r, aux[2:0], b8);
            zf_nxt = (b8 == 8'h00);
            sf_nxt = b8[7];
          end else begin
            w16 = logic16(lo[1:0], rf_r[aux[1:0]], lo[2] ? imm : rf_r[aux[3:2]]);
            rf_nxt[aux[1:0]] = w16;
            zf_nxt = (w16 == 16'h0000);
            sf_nxt = w16[15];
          end
        end
      end
      GRP_INCW: begin
        if (!lo[2]) begin
          w16 = rf_r[d16] + (lo[3] ? 16'hFFFF : 16'h0001);
          rf_nxt[d16] = w16;
          zf_nxt = (w16 == 16'h0000);
          sf_nxt = w16[15];
          of_nxt = lo[3] ? (w16 == 16'hFFFF) : (w16 == 16'h0000);
        end
      end
      GRP_INCB: begin
        b8 = rd8(rf_r, lo[2:0]) + (lo[3] ? 8'hFF : 8'h01);
        rf_nxt = wr8(rf_r, lo[2:0], b8);
        zf_nxt = (b8 == 8'h00);
        sf_nxt = b8[7];
        of_nxt = lo[3] ? (b8 == 8'hFF) : (b8 == 8'h00);
      end
      GRP_ADD, GRP_SUB: begin
        if (grp == GRP_SUB) begin
          sum17 = {1'b0, rf_r[d16]} - {1'b0, rf_r[s16]};
        end else begin
          sum17 = {1'b0, rf_r[d16]} + {1'b0, rf_r[s16]};
        end
        rf_nxt[d16] = sum17[15:0];
        zf_nxt = (sum17[15:0] == 16'h0000);
        sf_nxt = sum17[15];
        of_nxt = sum17[16];
      end
      GRP_ADDI, GRP_SUBI: begin
        if (lo < 4'd4) begin
          if (grp == GRP_SUBI) begin
            sum17 = {1'b0, rf_r[d16]} - {1'b0, imm};
          end else begin
            sum17 = {1'b0, rf_r[d16]} + {1'b0, imm};
          end
          rf_nxt[d16] = sum17[15:0];
          zf_nxt = (sum17[15:0] == 16'h0000);
          sf_nxt = sum17[15];
          of_nxt = sum17[16];
        end else if (lo == 4'd7 || lo[3]) begin
          if (lo[3]) begin
            b8 = aux;
          end else begin
            b8 = rd8(rf_r, aux[5:3]);
          end
          if (grp == GRP_SUBI) begin
            sum9 = {1'b0, rd8(rf_r, lo[3] ? lo[2:0] : aux[2:0])} - {1'b0, b8};
          end else begin
            sum9 = {1'b0, rd8(rf_r, lo[3] ? lo[2:0] : aux[2:0])} + {1'b0, b8};
          end
          rf_nxt = wr8(rf_r, lo[3] ? lo[2:0] : aux[2:0], sum9[7:0]);
          zf_nxt = (sum9[7:0] == 8'h00);
          sf_nxt = sum9[7];
          of_nxt = sum9[8];
        end
      end
      GRP_SHIFT: begin
        if (lo < 4'd6) begin
          if (aux[3]) begin
            rf_nxt[aux[1:0]] = shw;
          end else begin
            rf_nxt = wr8(rf_r, aux[2:0], shb);
          end
        end
      end
      GRP_JUMP: begin
        case (lo)
          JC_JMP:  taken = 1'b1;
          JC_JZ:   taken = zf_r;
          JC_JS:   taken = sf_r;
          JC_JO:   taken = of_r;
          JC_JNZ:  taken = !zf_r;
          JC_JNS:  taken = !sf_r;
          JC_JNO:  taken = !of_r;
          default: taken = 1'b0;
        endcase
        nh = lo[3] && (lo < 4'd14);
        if (taken) begin
          npc = pc + {{8{imm[7]}}, imm[7:0]};
        end
      end
      default: ;
    endcase
    out_data_nxt = {3'b000, nh, taken, npc, of_nxt, sf_nxt, zf_nxt, sp_nxt,
                    rf_nxt[3], rf_nxt[2], rf_nxt[1], rf_nxt[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_r        <= '0;
      sp_r        <= SP_RESET;
      zf_r        <= 1'b0;
      sf_r        <= 1'b0;
      of_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        rf_r        <= rf_nxt;
        sp_r        <= sp_nxt;
        zf_r        <= zf_nxt;
        sf_r        <= sf_nxt;
        of_r        <= of_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
